@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// Immediate-implication and next-cycle implication checks with async reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define CHK_IMPLY(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante holds -> cons holds in the next cycle
`define CHK_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/gccld_pkg.sv @@
// ----------------------------------------------------------------------------
// gccld_pkg
// Types and constants of the code/carrier lock detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gccld_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRACTION_BITS = 16;
    localparam int PWR_BITS = 48;
    localparam int DIF_BITS = 49;
    localparam int CNO_BITS = 24;
    localparam int ROOT_BITS = 32;
    localparam int MUL_A_BITS = 33;
    localparam int MUL_B_BITS = 32;
    localparam int PROD_BITS = 65;
    localparam int NUM_BITS = 68;
    localparam int DEN_BITS = 65;
    localparam int DSH_BITS = 88;

    localparam logic [19:0] SCALE_HZ = 20'd1000000;
    localparam logic [CNO_BITS-1:0] CNO_MAX = {CNO_BITS{1'b1}};

    typedef enum logic [2:0] {
        REG_PERIOD   = 3'd0,
        REG_GAIN     = 3'd1,
        REG_NB_GAIN  = 3'd2,
        REG_CNO_THR  = 3'd3,
        REG_CARR_THR = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] old_i;
        logic [SAMPLE_BITS-1:0] old_q;
        logic [SAMPLE_BITS-1:0] new_i;
        logic [SAMPLE_BITS-1:0] new_q;
    } mag_t;

    typedef struct packed {
        logic [16:0]         period;
        logic [15:0]         gain;
        logic [15:0]         nb_gain;
        logic [CNO_BITS-1:0] cno_thr;
        logic [15:0]         carr_thr;
    } cfg_t;

    // |x| of a two's complement sample; the most negative value maps to 2^(N-1)
    function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] x);
        magnitude = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

@@ rtl/gccld_front.sv @@
// ----------------------------------------------------------------------------
// gccld_front
// Input side: takes a transaction and pushes the four magnitudes to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gccld_front
(
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [gccld_pkg::SAMPLE_BITS-1:0] old_in_phase,
    input  logic signed [gccld_pkg::SAMPLE_BITS-1:0] old_quadrature,
    input  logic signed [gccld_pkg::SAMPLE_BITS-1:0] new_in_phase,
    input  logic signed [gccld_pkg::SAMPLE_BITS-1:0] new_quadrature,
    input  logic                             q_full,
    output logic                             q_push,
    output gccld_pkg::mag_t                  q_wdata
);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_wdata.old_i = gccld_pkg::magnitude(old_in_phase);
        q_wdata.old_q = gccld_pkg::magnitude(old_quadrature);
        q_wdata.new_i = gccld_pkg::magnitude(new_in_phase);
        q_wdata.new_q = gccld_pkg::magnitude(new_quadrature);
    end

endmodule

@@ rtl/gccld_fifo.sv @@
// ----------------------------------------------------------------------------
// gccld_fifo
// Short queue of magnitude sets between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gccld_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gccld_pkg::mag_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            rvalid,
    output gccld_pkg::mag_t rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gccld_pkg::mag_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign rvalid = (cnt_reg != '0);
    assign rdata  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `CHK_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(DEPTH))
    `CHK_NEXT(a_cnt_inc, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

@@ rtl/gccld_isqrt.sv @@
// ----------------------------------------------------------------------------
// gccld_isqrt
// Bit-serial square root of p*2^32, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gccld_isqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [31:0]                       radicand,
    output logic                              busy,
    output logic [gccld_pkg::ROOT_BITS-1:0]   root
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        take;

    assign busy   = busy_reg;
    assign root   = root_reg;
    assign rem_sh = {rem_reg, rad_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {radicand, 32'b0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
            root_reg <= {root_reg[30:0], take};
        end
    end

endmodule

@@ rtl/gccld_back.sv @@
// ----------------------------------------------------------------------------
// gccld_back
// Sequencer: powers, roots, four averages, lock tests and the C/N0 divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gccld_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  gccld_pkg::cfg_t                    cfg,
    input  logic                               q_valid,
    input  gccld_pkg::mag_t                    q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               code_locked,
    output logic                               carrier_locked,
    output logic [gccld_pkg::CNO_BITS-1:0]     cno_ratio
);

    localparam logic [4:0] DIV_LAST = 5'd23;
    localparam logic [2:0] OP_NBD   = 3'd0;
    localparam logic [2:0] OP_NBP   = 3'd1;
    localparam logic [2:0] OP_PC    = 3'd2;
    localparam logic [2:0] OP_PN    = 3'd3;
    localparam logic [2:0] OP_CARR  = 3'd4;

    typedef enum logic [20:0] {
        S_IDLE = 21'h000001, S_SQ0 = 21'h000002, S_SQ1 = 21'h000004,
        S_SQ2  = 21'h000008, S_SQ3 = 21'h000010, S_SQ4 = 21'h000020,
        S_ROOT = 21'h000040, S_NS  = 21'h000080, S_NSR = 21'h000100,
        S_SMH  = 21'h000200, S_SML = 21'h000400, S_SMU = 21'h000800,
        S_NUMH = 21'h001000, S_NUML = 21'h002000, S_DENH = 21'h004000,
        S_DENL = 21'h008000, S_DENS = 21'h010000, S_SAT = 21'h020000,
        S_DIV  = 21'h040000, S_FIN = 21'h080000, S_DONE = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    gccld_pkg::mag_t mag_reg;
    logic [31:0] ii_reg, qq_reg, pp_reg;
    logic [gccld_pkg::PWR_BITS-1:0] noise_reg;
    logic [gccld_pkg::PWR_BITS-1:0] pc_reg, pn_reg, nbp_reg;
    logic [gccld_pkg::DIF_BITS-1:0] nbd_reg;
    logic [2:0]  op_reg;
    logic [48:0] sacc_reg;
    logic [gccld_pkg::PROD_BITS-1:0] prod_reg, prod_next;
    logic [gccld_pkg::MUL_A_BITS-1:0] mul_a;
    logic [gccld_pkg::MUL_B_BITS-1:0] mul_b;
    logic [gccld_pkg::NUM_BITS-1:0] num_reg;
    logic [gccld_pkg::DEN_BITS-1:0] den_reg;
    logic [gccld_pkg::DSH_BITS-1:0] dsh_reg;
    logic [gccld_pkg::CNO_BITS-1:0] q_reg;
    logic [4:0]  div_cnt_reg;
    logic        code_w_reg, carr_w_reg;
    logic [gccld_pkg::CNO_BITS-1:0] cno_w_reg;
    logic        res_valid_reg, code_reg, carr_reg;
    logic [gccld_pkg::CNO_BITS-1:0] cno_reg;

    // square root units
    logic        sq_start, sq_busy_c, sq_busy_p;
    logic [31:0] pc_sum, pp_sum;
    logic [31:0] root_c, root_p, dlt_root;

    // smoothing operands
    logic [49:0] sm_p, sm_c, sm_d, sm_new;
    logic [48:0] sm_m, sm_s;
    logic [15:0] sm_g;
    logic        sm_neg;
    logic [48:0] x_diff;
    logic [47:0] x_mean, x_nbp;
    logic        sat, div_ge, res_load;

    assign pc_sum = ii_reg + qq_reg;
    assign pp_sum = pp_reg + prod_reg[31:0];
    assign sq_start = (state_reg == S_SQ4);

    gccld_isqrt u_sqrt_cur
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (pc_sum),
        .busy     (sq_busy_c),
        .root     (root_c)
    );

    gccld_isqrt u_sqrt_prev
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (pp_sum),
        .busy     (sq_busy_p),
        .root     (root_p)
    );

    assign dlt_root = (root_c >= root_p) ? (root_c - root_p) : (root_p - root_c);

    assign x_diff = {33'({1'b0, ii_reg} - {1'b0, qq_reg}), 16'b0};
    assign x_mean = {33'({1'b0, pp_reg} + {1'b0, pc_sum}), 15'b0};
    assign x_nbp  = {pc_sum, 16'b0};

    always_comb
    begin
        sm_p = '0;
        sm_c = {2'b00, nbp_reg};
        sm_g = cfg.carr_thr;
        case (op_reg)
            OP_NBD:
            begin
                sm_p = {nbd_reg[48], nbd_reg};
                sm_c = {x_diff[48], x_diff};
                sm_g = cfg.gain;
            end
            OP_NBP:
            begin
                sm_p = {2'b00, nbp_reg};
                sm_c = {2'b00, x_nbp};
                sm_g = cfg.nb_gain;
            end
            OP_PC:
            begin
                sm_p = {2'b00, pc_reg};
                sm_c = {2'b00, x_mean};
                sm_g = cfg.gain;
            end
            OP_PN:
            begin
                sm_p = {2'b00, pn_reg};
                sm_c = {2'b00, noise_reg};
                sm_g = cfg.gain;
            end
            default:
            begin
                sm_p = '0;
                sm_c = {2'b00, nbp_reg};
                sm_g = cfg.carr_thr;
            end
        endcase
    end

    assign sm_d   = sm_c - sm_p;
    assign sm_neg = sm_d[49];
    assign sm_m   = sm_neg ? 49'(-sm_d) : sm_d[48:0];
    assign sm_s   = sacc_reg + {33'b0, prod_reg[31:16]};
    assign sm_new = sm_neg ? (sm_p - {1'b0, sm_s}) : (sm_p + {1'b0, sm_s});

    // shared multiplier, registered
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ0:
            begin
                mul_a = {17'b0, mag_reg.new_i};
                mul_b = {16'b0, mag_reg.new_i};
            end
            S_SQ1:
            begin
                mul_a = {17'b0, mag_reg.new_q};
                mul_b = {16'b0, mag_reg.new_q};
            end
            S_SQ2:
            begin
                mul_a = {17'b0, mag_reg.old_i};
                mul_b = {16'b0, mag_reg.old_i};
            end
            S_SQ3:
            begin
                mul_a = {17'b0, mag_reg.old_q};
                mul_b = {16'b0, mag_reg.old_q};
            end
            S_NS:
            begin
                mul_a = {1'b0, dlt_root};
                mul_b = dlt_root;
            end
            S_SMH:
            begin
                mul_a = sm_m[48:16];
                mul_b = {16'b0, sm_g};
            end
            S_SML:
            begin
                mul_a = {17'b0, sm_m[15:0]};
                mul_b = {16'b0, sm_g};
            end
            S_NUMH:
            begin
                mul_a = {1'b0, pc_reg[47:16]};
                mul_b = {12'b0, gccld_pkg::SCALE_HZ};
            end
            S_NUML:
            begin
                mul_a = {17'b0, pc_reg[15:0]};
                mul_b = {12'b0, gccld_pkg::SCALE_HZ};
            end
            S_DENH:
            begin
                mul_a = {1'b0, pn_reg[47:16]};
                mul_b = {15'b0, cfg.period};
            end
            S_DENL:
            begin
                mul_a = {17'b0, pn_reg[15:0]};
                mul_b = {15'b0, cfg.period};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = gccld_pkg::PROD_BITS'(mul_a) * gccld_pkg::PROD_BITS'(mul_b);

    assign sat    = ({21'b0, num_reg} >= {den_reg, 24'b0});
    assign div_ge = ({20'b0, num_reg} >= dsh_reg);
    assign res_load = (state_reg == S_DONE) && !(res_valid_reg && out_stall);
    assign q_pop  = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_SQ0;
            S_SQ0:  state_next = S_SQ1;
            S_SQ1:  state_next = S_SQ2;
            S_SQ2:  state_next = S_SQ3;
            S_SQ3:  state_next = S_SQ4;
            S_SQ4:  state_next = S_ROOT;
            S_ROOT: if (!sq_busy_c && !sq_busy_p) state_next = S_NS;
            S_NS:   state_next = S_NSR;
            S_NSR:  state_next = S_SMH;
            S_SMH:  state_next = S_SML;
            S_SML:  state_next = S_SMU;
            S_SMU:
            begin
                if (op_reg != OP_CARR)
                    state_next = S_SMH;
                else if (pn_reg == '0 || cfg.period == '0)
                    state_next = S_DONE;
                else
                    state_next = S_NUMH;
            end
            S_NUMH: state_next = S_NUML;
            S_NUML: state_next = S_DENH;
            S_DENH: state_next = S_DENL;
            S_DENL: state_next = S_DENS;
            S_DENS: state_next = S_SAT;
            S_SAT:  state_next = sat ? S_DONE : S_DIV;
            S_DIV:  if (div_cnt_reg == DIV_LAST) state_next = S_FIN;
            S_FIN:  state_next = S_DONE;
            S_DONE: if (res_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            pc_reg        <= '0;
            pn_reg        <= '0;
            nbd_reg       <= '0;
            nbp_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
            if (state_reg == S_SMU)
            begin
                case (op_reg)
                    OP_NBD: nbd_reg <= sm_new[48:0];
                    OP_NBP: nbp_reg <= sm_new[47:0];
                    OP_PC:  pc_reg  <= sm_new[47:0];
                    OP_PN:  pn_reg  <= sm_new[47:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (q_pop)
            mag_reg <= q_data;
        if (state_reg == S_SQ1)
            ii_reg <= prod_reg[31:0];
        if (state_reg == S_SQ2)
            qq_reg <= prod_reg[31:0];
        if (state_reg == S_SQ3)
            pp_reg <= prod_reg[31:0];
        if (state_reg == S_SQ4)
            pp_reg <= pp_sum;
        if (state_reg == S_NSR)
        begin
            noise_reg <= prod_reg[63:16];
            op_reg    <= OP_NBD;
        end
        if (state_reg == S_SML)
            sacc_reg <= prod_reg[48:0];
        if (state_reg == S_SMU)
        begin
            op_reg <= op_reg + 1'b1;
            if (op_reg == OP_CARR)
            begin
                carr_w_reg <= !nbd_reg[48] && (nbd_reg != '0) && (nbp_reg != '0)
                              && (nbd_reg > sm_s);
                cno_w_reg  <= gccld_pkg::CNO_MAX;
                code_w_reg <= (pc_reg != '0);
            end
        end
        if (state_reg == S_NUML)
            num_reg <= {prod_reg[51:0], 16'b0};
        if (state_reg == S_DENH)
            num_reg <= num_reg + gccld_pkg::NUM_BITS'(prod_reg[35:0]);
        if (state_reg == S_DENL)
            den_reg <= {prod_reg[48:0], 16'b0};
        if (state_reg == S_DENS)
            den_reg <= den_reg + gccld_pkg::DEN_BITS'(prod_reg[32:0]);
        if (state_reg == S_SAT)
        begin
            dsh_reg     <= {den_reg, 23'b0};
            q_reg       <= '0;
            div_cnt_reg <= '0;
            code_w_reg  <= 1'b1;
        end
        if (state_reg == S_DIV)
        begin
            if (div_ge)
                num_reg <= num_reg - dsh_reg[67:0];
            q_reg       <= {q_reg[22:0], div_ge};
            dsh_reg     <= {1'b0, dsh_reg[87:1]};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (state_reg == S_FIN)
        begin
            cno_w_reg  <= q_reg;
            code_w_reg <= (q_reg > cfg.cno_thr) || ((q_reg == cfg.cno_thr) && (num_reg != '0));
        end
        if (res_load)
        begin
            code_reg <= code_w_reg;
            carr_reg <= carr_w_reg;
            cno_reg  <= cno_w_reg;
        end
    end

    assign out_valid      = res_valid_reg;
    assign code_locked    = code_reg;
    assign carrier_locked = carr_reg;
    assign cno_ratio      = cno_reg;

    `CHK_IMPLY(a_div_cnt, clk, rst_n, state_reg == S_DIV, div_cnt_reg <= DIV_LAST)
    `CHK_IMPLY(a_root_done, clk, rst_n, state_reg == S_NS, !sq_busy_c && !sq_busy_p)
    `CHK_NEXT(a_res_load, clk, rst_n, res_load, res_valid_reg)

endmodule

@@ rtl/gnss_code_carrier_lock_detector.sv @@
// ----------------------------------------------------------------------------
// gnss_code_carrier_lock_detector
// C/N0 estimator with code and carrier lock flags for one tracking channel.
// ----------------------------------------------------------------------------
// Each input transaction carries the previous and current prompt I/Q dumps and
// yields exactly one output transaction: C/N0 in Hz (24 b, floor, saturated),
// code lock (C/N0 above cno_threshold) and carrier lock (narrowband I2-Q2 over
// I2+Q2 average above carrier_threshold). The two 32-step square roots and the
// 24-step restoring divide set the latency; the divide and its operand products
// are skipped when the noise average or period is zero. The back end handles
// one transaction at a time. A small input queue takes new transactions while
// the back end works and while a result waits.
// Registers (APB, byte address 4*index): 0 period_us, 1 filter gain,
// 2 narrowband power gain, 3 C/N0 threshold, 4 carrier threshold (Q0.16).
// Write registers only while the block is idle.
`timescale 1ns / 1ps

module gnss_code_carrier_lock_detector
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input transactions
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] old_in_phase,
    input  logic signed [15:0] old_quadrature,
    input  logic signed [15:0] new_in_phase,
    input  logic signed [15:0] new_quadrature,
    // output transactions
    output logic        out_valid,
    input  logic        out_stall,
    output logic        code_locked,
    output logic        carrier_locked,
    output logic [23:0] cno_ratio,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gccld_pkg::cfg_t cfg_reg;
    gccld_pkg::reg_idx_t reg_idx;
    logic            wr_en;

    logic            q_push, q_full, q_pop, q_valid;
    gccld_pkg::mag_t q_wdata, q_rdata;

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = gccld_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period   <= 17'd1000;
            cfg_reg.gain     <= 16'd655;
            cfg_reg.nb_gain  <= 16'd655;
            cfg_reg.cno_thr  <= 24'd1000;
            cfg_reg.carr_thr <= 16'd56754;   // 0.866 in Q0.16
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                gccld_pkg::REG_PERIOD:   cfg_reg.period   <= pwdata[16:0];
                gccld_pkg::REG_GAIN:     cfg_reg.gain     <= pwdata[15:0];
                gccld_pkg::REG_NB_GAIN:  cfg_reg.nb_gain  <= pwdata[15:0];
                gccld_pkg::REG_CNO_THR:  cfg_reg.cno_thr  <= pwdata[23:0];
                gccld_pkg::REG_CARR_THR: cfg_reg.carr_thr <= pwdata[15:0];
                default: ;                // unmapped addresses are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gccld_pkg::REG_PERIOD:   prdata = {15'b0, cfg_reg.period};
            gccld_pkg::REG_GAIN:     prdata = {16'b0, cfg_reg.gain};
            gccld_pkg::REG_NB_GAIN:  prdata = {16'b0, cfg_reg.nb_gain};
            gccld_pkg::REG_CNO_THR:  prdata = {8'b0, cfg_reg.cno_thr};
            gccld_pkg::REG_CARR_THR: prdata = {16'b0, cfg_reg.carr_thr};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // front end: magnitudes into the queue
    // ------------------------------------------------------------------
    gccld_front u_front
    (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .old_in_phase   (old_in_phase),
        .old_quadrature (old_quadrature),
        .new_in_phase   (new_in_phase),
        .new_quadrature (new_quadrature),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    gccld_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    // ------------------------------------------------------------------
    // back end: averages, lock tests, C/N0 divide, result register
    // ------------------------------------------------------------------
    gccld_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_locked    (code_locked),
        .carrier_locked (carrier_locked),
        .cno_ratio      (cno_ratio)
    );

endmodule
